// File: sv/assert_macros.svh
// Assertion macros for the RTL of the random bit walk path block.
// Active in simulation; defined empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// File: sv/rbw_pkg.sv
// Package for the random bit walk path block: payload structs, register
// indexes and default sizes. No dependencies.
`default_nettype none

package rbw_pkg;

  localparam int RWORD_W       = 32;
  localparam int POS_W         = 56;
  localparam int WV_W          = 24;
  localparam int SCALE_W       = 32;
  localparam int CFG_INDEX_W   = 1;
  localparam int WALK_BITS_DEF = 24;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = 1'b1;

  typedef struct packed {
    logic [RWORD_W-1:0] random_word;
    logic               path_start;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [WV_W-1:0]  walk_value;
    logic                    last_of_word;
  } out_t;

endpackage

`default_nettype wire

// File: sv/rbw_stepper.sv
// Word holding register and walk sequencer: emits one walk sample per cycle while
// smp_stall is low, updates the saturating walk. Uses rbw_pkg and assert_macros.svh.
`default_nettype none

module rbw_stepper #(
  parameter int WALK_BITS = rbw_pkg::WALK_BITS_DEF,
  parameter int WORD_BITS = rbw_pkg::WORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step_mode,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rbw_pkg::in_t                in_data,
  output logic                             smp_valid,
  input  wire logic                        smp_stall,
  output logic signed [WALK_BITS-1:0]      smp_walk,
  output logic                             smp_last
);
  import rbw_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W   = $clog2(WORD_BITS);
  localparam int ONES_W  = $clog2(WORD_BITS + 1);
  localparam int DELTA_W = $clog2(WORD_BITS) + 2;
  localparam int SUM_W   = WALK_BITS + 2;

  localparam logic signed [SUM_W-1:0] WALK_MAX =
    {{(SUM_W - WALK_BITS + 1){1'b0}}, {(WALK_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] WALK_MIN =
    {{(SUM_W - WALK_BITS + 1){1'b1}}, {(WALK_BITS - 1){1'b0}}};

  logic                        w_valid;
  logic [WORD_BITS-1:0]        word;
  logic [CNT_W-1:0]            cnt;
  logic                        first;
  logic                        start;
  logic signed [DELTA_W-1:0]   pop_delta;
  logic signed [WALK_BITS-1:0] walk;
  logic signed [WALK_BITS-1:0] walk_next;

  logic                        accept;
  logic                        issue;
  logic                        is_last;
  logic [WORD_BITS-1:0]        in_word;
  logic [ONES_W-1:0]           ones;
  logic signed [DELTA_W-1:0]   pop_delta_next;
  logic signed [DELTA_W-1:0]   delta;
  logic signed [WALK_BITS-1:0] cur_walk;
  logic signed [SUM_W-1:0]     sum;

  assign in_word = WORD_BITS'(in_data.random_word);

  always_comb begin
    ones = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      ones = ones + ONES_W'(in_word[i]);
    end
  end

  // 2*ones - WORD_BITS; modular math is exact since the result fits
  assign pop_delta_next = (DELTA_W'(ones) <<< 1) - DELTA_W'(WORD_BITS);

  assign is_last  = step_mode | (cnt == CNT_W'(WORD_BITS - 1));
  assign issue    = w_valid && !smp_stall;
  assign accept   = in_valid && !in_stall;
  assign in_stall = w_valid && !(issue && is_last);

  // a path start clears the walk ahead of the first sample of the word
  assign cur_walk = (first && start) ? '0 : walk;
  assign delta    = step_mode ? pop_delta : (word[0] ? DELTA_W'(1) : -DELTA_W'(1));
  assign sum      = SUM_W'(cur_walk) + SUM_W'(delta);

  always_comb begin
    if (sum > WALK_MAX) begin
      walk_next = WALK_BITS'(WALK_MAX);
    end else if (sum < WALK_MIN) begin
      walk_next = WALK_BITS'(WALK_MIN);
    end else begin
      walk_next = WALK_BITS'(sum);
    end
  end

  assign smp_valid = w_valid;
  assign smp_walk  = cur_walk;
  assign smp_last  = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      walk    <= '0;
    end else begin
      if (accept) begin
        w_valid <= 1'b1;
      end else if (issue && is_last) begin
        w_valid <= 1'b0;
      end
      if (issue) begin
        walk <= walk_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word      <= in_word;
      cnt       <= '0;
      first     <= 1'b1;
      start     <= in_data.path_start;
      pop_delta <= pop_delta_next;
    end else if (issue) begin
      // advance to the next bit of the word
      word  <= word >> 1;
      cnt   <= cnt + CNT_W'(1);
      first <= 1'b0;
    end
  end

  `ASSERT_CLK(a_word_continues, clk, rst, issue && !is_last && !rst |=> w_valid)
  `ASSERT_NEVER(a_first_at_zero, clk, rst, w_valid && !first && cnt == '0 && !step_mode)
  `ASSERT_CLK(a_unit_step, clk, rst,
    issue && !step_mode && !rst |=>
      (SUM_W'(walk) - SUM_W'($past(cur_walk)) == SUM_W'(1)) ||
      (SUM_W'(walk) - SUM_W'($past(cur_walk)) == '1) ||
      (SUM_W'(walk) - SUM_W'($past(cur_walk)) == '0))

endmodule

`default_nettype wire

// File: sv/random_bit_walk_path.sv
// Random bit walk path:
//   Input channel (in_valid / in_stall / in_data) takes one 32-bit random
//   word and a path start flag per beat. Output channel (out_valid /
//   out_stall / out_data) returns one walk sample per beat: scaled position
//   (Q32.24), raw walk and a flag on the last sample of the word.
//   Configuration (cfg_write / cfg_index / cfg_data) sets step_mode and the
//   Q8.24 scale; write only while the block is idle.
//   step_mode 0: a word gives WORD_BITS samples, LSB first, one per cycle
//   while the output is not stalled; the next word is taken in the cycle
//   its predecessor issues its last sample.
//   step_mode 1: a word gives one sample; one word per cycle unless stalled.
//   A word's beat is registered in the sequencer; its first sample then goes
//   through the output register. The single sample sequencer sets the rate;
//   the scale multiply sits between it and the output register.
//   Reset: walk cleared, step_mode 0, scale 1.0, both channels empty.
//   When out_stall is high while out_valid is set, the output register holds
//   and the sequencer waits; one more word may be held at the input meanwhile.
// Depends on rbw_pkg and rbw_stepper.
`default_nettype none

module random_bit_walk_path #(
  parameter int WALK_BITS = rbw_pkg::WALK_BITS_DEF,
  parameter int WORD_BITS = rbw_pkg::WORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire rbw_pkg::in_t                        in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output rbw_pkg::out_t                            out_data,
  input  wire logic                                cfg_write,
  input  wire logic [rbw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [rbw_pkg::SCALE_W-1:0]         cfg_data
);
  import rbw_pkg::*;

  localparam int PROD_W = WALK_BITS + SCALE_W + 1;
  localparam int EXT_W  = (PROD_W > POS_W) ? PROD_W : POS_W;
  localparam int WV_EXT = (WALK_BITS > WV_W) ? WALK_BITS : WV_W;

  logic               step_mode;
  logic [SCALE_W-1:0] scale;

  logic                        smp_valid;
  logic                        smp_stall;
  logic signed [WALK_BITS-1:0] smp_walk;
  logic                        smp_last;

  logic signed [PROD_W-1:0]    prod;
  logic signed [EXT_W-1:0]     prod_ext;
  logic signed [WV_EXT-1:0]    walk_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_mode <= 1'b0;
      scale     <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_MODE: step_mode <= cfg_data[0];
        REG_SCALE:     scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  rbw_stepper #(
    .WALK_BITS (WALK_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_stepper (
    .clk       (clk),
    .rst       (rst),
    .step_mode (step_mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp_walk  (smp_walk),
    .smp_last  (smp_last)
  );

  // scale is unsigned: zero-extend it into the signed product
  assign prod     = PROD_W'(smp_walk) * PROD_W'($signed({1'b0, scale}));
  assign prod_ext = EXT_W'(prod);
  assign walk_ext = WV_EXT'(smp_walk);

  assign smp_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!smp_stall) begin
      out_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid && !smp_stall) begin
      out_data.position     <= prod_ext[POS_W-1:0];
      out_data.walk_value   <= walk_ext[WV_W-1:0];
      out_data.last_of_word <= smp_last;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Testbench for random_bit_walk_path: directed table then random phases, every
// output beat checked against a walk predictor kept in this file.
// Depends on rbw_pkg and the random_bit_walk_path RTL.
`timescale 1ns / 1ps

module tb_top;
  import rbw_pkg::*;

  localparam logic MODE_PER_BIT  = 1'b0;
  localparam logic MODE_POPCOUNT = 1'b1;

  localparam int WALK_HI      = (1 << (WALK_BITS_DEF - 1)) - 1;
  localparam int WALK_LO      = -WALK_HI - 1;
  localparam int RANDOM_WORDS = 130;
  localparam int HOLD_CYCLES  = 240;
  localparam int TAIL_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [SCALE_W-1:0]    data;
    logic                  start;
    logic [CFG_INDEX_W-1:0] index;
    int                    reps;
    logic                  pinned;
    out_t                  want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [SCALE_W-1:0]     cfg_data = '0;

  // predictor state, mirrors the block's walk and registers
  logic signed [WV_W-1:0] walk_pos = '0;
  logic                   walk_mode = MODE_PER_BIT;
  logic [SCALE_W-1:0]     walk_scale = SCALE_RESET;
  out_t                   expected_samples[$];

  dir_row_t dir_rows[$];
  int  mismatches = 0;
  int  samples_checked = 0;
  int  beats_sent = 0;
  int  reg_phases = 0;
  int  burst_left = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  int  cycle_count = 0;
  bit  fast_lane = 1'b0;

  random_bit_walk_path i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [WV_W-1:0] clamp_walk(input logic signed [WV_W-1:0] w,
                                                        input int d);
    int sum;
    sum = int'(w) + d;
    if (sum > WALK_HI) sum = WALK_HI;
    if (sum < WALK_LO) sum = WALK_LO;
    return WV_W'(sum);
  endfunction

  function automatic out_t sample_now(input logic last);
    logic signed [63:0] wide_walk;
    logic [63:0]        product;
    out_t               s;
    wide_walk = walk_pos;
    product = wide_walk * {32'd0, walk_scale};
    s.position = product[POS_W-1:0];
    s.walk_value = walk_pos;
    s.last_of_word = last;
    return s;
  endfunction

  task automatic predict_word(input in_t beat);
    int ones;
    if (beat.path_start) walk_pos = '0;
    if (walk_mode == MODE_PER_BIT) begin
      for (int b = 0; b < WORD_BITS_DEF; b++) begin
        expected_samples.push_back(sample_now(b == WORD_BITS_DEF - 1));
        walk_pos = clamp_walk(walk_pos, beat.random_word[b] ? 1 : -1);
      end
    end else begin
      ones = $countones(beat.random_word);
      expected_samples.push_back(sample_now(1'b1));
      walk_pos = clamp_walk(walk_pos, 2 * ones - WORD_BITS_DEF);
    end
  endtask

  function automatic dir_row_t beat_row(input logic [31:0] word, input logic start,
                                        input int reps, input logic pinned,
                                        input logic [POS_W-1:0] pos,
                                        input logic [WV_W-1:0] wv, input logic last);
    dir_row_t r;
    r.kind = ROW_BEAT;
    r.data = word;
    r.start = start;
    r.index = '0;
    r.reps = reps;
    r.pinned = pinned;
    r.want.position = pos;
    r.want.walk_value = wv;
    r.want.last_of_word = last;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [SCALE_W-1:0] data);
    dir_row_t r;
    r = beat_row(data, 1'b0, 0, 1'b0, '0, '0, 1'b0);
    r.kind = ROW_REG;
    r.index = idx;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat, hold it until taken, then maybe end the burst with a gap.
  task automatic send_beat(input in_t beat, input logic pinned, input out_t want);
    int first;
    int gap;
    in_data <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    first = expected_samples.size();
    predict_word(beat);
    if (pinned) expected_samples[first] = want;
    beats_sent++;
    if (!fast_lane) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  task automatic drain_samples();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  // Caller lowers cfg_write after the last write of a group.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [SCALE_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_STEP_MODE) walk_mode = data[0];
    else if (idx == REG_SCALE) walk_scale = data;
  endtask

  task automatic report_sample(input string why, input out_t want, input out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("tb_top: %s: want pos=%h walk=%h last=%b, got pos=%h walk=%h last=%b",
               why, want.position, want.walk_value, want.last_of_word,
               got.position, got.walk_value, got.last_of_word);
  endtask

  always @(posedge clk) begin : check_samples
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      samples_checked++;
      if (expected_samples.size() == 0) begin
        report_sample("sample with nothing pending", '0, out_data);
      end else begin
        want = expected_samples.pop_front();
        if (out_data.position !== want.position || out_data.walk_value !== want.walk_value ||
            out_data.last_of_word !== want.last_of_word)
          report_sample("sample mismatch", want, out_data);
      end
    end
  end

  // Receiver: runs of random stall density, plus long hold-offs on request.
  initial begin : receiver
    int run_left;
    int stall_pct;
    run_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else if (fast_lane) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(4, 40);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        run_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d samples pending",
               cycle_count, expected_samples.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    in_t                beat;
    logic [SCALE_W-1:0] mode_word;
    logic [SCALE_W-1:0] scale_pick;
    int                 random_beats;
    int                 phase;
    int                 phase_len;

    // per-bit mode, scale 1.0 after reset
    dir_rows.push_back(beat_row(32'hFFFF_FFFF, 1'b1, 1, 1'b1, '0, '0, 1'b0));
    dir_rows.push_back(beat_row(32'h0000_0000, 1'b0, 1, 1'b1,
                                56'h00_0000_2000_0000, 24'd32, 1'b0));
    dir_rows.push_back(beat_row(32'hAAAA_AAAA, 1'b0, 1, 1'b1, '0, '0, 1'b0));
    dir_rows.push_back(beat_row(32'h5555_5555, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    dir_rows.push_back(beat_row(32'h0000_0000, 1'b1, 1, 1'b1, '0, '0, 1'b0));
    dir_rows.push_back(beat_row(32'h1234_5678, 1'b0, 1, 1'b1,
                                56'hFF_FFFF_E000_0000, 24'hFF_FFE0, 1'b0));
    dir_rows.push_back(reg_row(REG_SCALE, 32'hFFFF_FFFF));
    dir_rows.push_back(beat_row(32'h0000_0000, 1'b1, 1, 1'b1, '0, '0, 1'b0));
    dir_rows.push_back(beat_row(32'hFFFF_FFFF, 1'b0, 1, 1'b0, '0, '0, 1'b0));
    dir_rows.push_back(reg_row(REG_SCALE, 32'h0000_0000));
    dir_rows.push_back(beat_row(32'hDEAD_BEEF, 1'b0, 1, 1'b1, '0, '0, 1'b0));
    // popcount mode; upper data bits must be dropped
    dir_rows.push_back(reg_row(REG_STEP_MODE, 32'hFFFF_FFFF));
    dir_rows.push_back(reg_row(REG_SCALE, SCALE_RESET));
    dir_rows.push_back(beat_row(32'hFFFF_FFFF, 1'b1, 1, 1'b1, '0, '0, 1'b1));
    dir_rows.push_back(beat_row(32'hFFFF_FFFF, 1'b0, 1, 1'b1,
                                56'h00_0000_2000_0000, 24'd32, 1'b1));
    dir_rows.push_back(beat_row(32'h0000_0000, 1'b0, 1, 1'b1,
                                56'h00_0000_4000_0000, 24'd64, 1'b1));
    dir_rows.push_back(beat_row(32'h0000_FFFF, 1'b0, 1, 1'b1,
                                56'h00_0000_2000_0000, 24'd32, 1'b1));
    dir_rows.push_back(beat_row(32'h8000_0001, 1'b0, 1, 1'b1,
                                56'h00_0000_2000_0000, 24'd32, 1'b1));
    dir_rows.push_back(reg_row(REG_STEP_MODE, 32'hFFFF_FFFE));
    dir_rows.push_back(beat_row(32'hFFFF_FFFF, 1'b0, 1, 1'b1,
                                56'h00_0000_0400_0000, 24'd4, 1'b0));
    dir_rows.push_back(beat_row(32'h0F0F_0F0F, 1'b1, 1, 1'b1, '0, '0, 1'b0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < dir_rows.size(); r++) begin
      if (dir_rows[r].kind == ROW_REG) begin
        if (r == 0 || dir_rows[r-1].kind != ROW_REG) begin
          drain_samples();
          reg_phases++;
        end
        write_reg(dir_rows[r].index, dir_rows[r].data);
        if (r == dir_rows.size() - 1 || dir_rows[r+1].kind != ROW_REG) cfg_write <= 1'b0;
      end else begin
        fast_lane = (dir_rows[r].reps > 1);
        for (int k = 0; k < dir_rows[r].reps; k++) begin
          beat.random_word = dir_rows[r].data;
          beat.path_start = (k == 0) ? dir_rows[r].start : 1'b0;
          send_beat(beat, dir_rows[r].pinned && k == 0, dir_rows[r].want);
        end
        fast_lane = 1'b0;
      end
    end

    random_beats = 0;
    phase = 0;
    while (random_beats < RANDOM_WORDS) begin
      drain_samples();
      reg_phases++;
      mode_word = $urandom;
      if (phase == 0) mode_word[0] = MODE_PER_BIT;
      else if (phase == 1) mode_word[0] = MODE_POPCOUNT;
      case ($urandom_range(0, 3))
        0: scale_pick = '0;
        1: scale_pick = '1;
        2: scale_pick = SCALE_RESET;
        default: scale_pick = $urandom;
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_SCALE, scale_pick);
        write_reg(REG_STEP_MODE, mode_word);
      end else begin
        write_reg(REG_STEP_MODE, mode_word);
        write_reg(REG_SCALE, scale_pick);
      end
      cfg_write <= 1'b0;
      phase_len = $urandom_range(6, 18);
      for (int k = 0; k < phase_len; k++) begin
        // the first two phases hold the receiver off so the block backs up
        if (phase < 2 && k == 2) hold_requests++;
        else if (k > 0 && $urandom_range(0, 19) == 0) drain_samples();
        beat.path_start = (k == 0 && $urandom_range(0, 1)) || ($urandom_range(0, 11) == 0);
        beat.random_word = pick_word();
        send_beat(beat, 1'b0, '0);
        random_beats++;
      end
      phase++;
    end

    drain_samples();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d words in %0d register settings, %0d samples checked",
             beats_sent, reg_phases, samples_checked);
    $display("tb_top: both step modes and scale extremes, %0d receiver hold-offs, %0d mismatches",
             holds_served, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
